[rtl/awa_pkg.sv]
// shared types, widths and constants for the ackermann wheel angle block
// used by awa_vec_cordic and ackermann_wheel_angles
`default_nettype none
package awa_pkg;

   localparam int AngleFracBits = 13;
   localparam int CordicIters = 16;
   localparam int FShift = 30 - AngleFracBits;
   localparam int RotWidth = 34;
   localparam int VecWidth = 52;
   localparam int ZWidth = 33;
   localparam int MulWidth = 47;
   localparam int HalfPi = 12868;

   localparam logic [1:0] RegWheelbase = 2'd0;
   localparam logic [1:0] RegTrackWidth = 2'd1;
   localparam logic [1:0] RegSteerLimit = 2'd2;
   localparam logic [1:0] RegDeadZone = 2'd3;

   typedef struct packed {
      logic valid;
      logic zero;
      logic pos;
      logic fault_left;
      logic fault_right;
   } side_type;

   function automatic logic signed [ZWidth-1:0] step_angle(input int i);
      logic signed [ZWidth-1:0] a;
      case (i)
         0: a = 33'sd843314856;
         1: a = 33'sd497837829;
         2: a = 33'sd263043836;
         3: a = 33'sd133525158;
         4: a = 33'sd67021686;
         5: a = 33'sd33543515;
         6: a = 33'sd16775850;
         7: a = 33'sd8388437;
         8: a = 33'sd4194282;
         9: a = 33'sd2097149;
         10: a = 33'sd1048575;
         11: a = 33'sd524287;
         12: a = 33'sd262143;
         13: a = 33'sd131071;
         14: a = 33'sd65535;
         15: a = 33'sd32767;
         16: a = 33'sd16383;
         17: a = 33'sd8191;
         18: a = 33'sd4095;
         19: a = 33'sd2047;
         20: a = 33'sd1023;
         21: a = 33'sd511;
         22: a = 33'sd255;
         default: a = 33'sd127;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

[rtl/awa_vec_cordic.sv]
// pipelined vectoring cordic, one iteration per register stage
// depends on awa_pkg
`default_nettype none
module awa_vec_cordic
   import awa_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       advance,
   input  wire logic signed [VecWidth-1:0] den,
   input  wire logic signed [VecWidth-1:0] num,
   output logic signed [ZWidth-1:0]        angle
);

   logic signed [VecWidth-1:0] x_ff [1:CordicIters];
   logic signed [VecWidth-1:0] y_ff [1:CordicIters];
   logic signed [ZWidth-1:0]   z_ff [1:CordicIters];

   for (genvar i = 0; i < CordicIters; i++) begin : g_stage
      logic signed [VecWidth-1:0] x_cur, y_cur;
      logic signed [ZWidth-1:0]   z_cur;
      logic signed [VecWidth-1:0] x_in, y_in;
      logic signed [ZWidth-1:0]   z_in;
      if (i == 0) begin : g_first
         assign x_cur = den;
         assign y_cur = num;
         assign z_cur = '0;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign z_cur = z_ff[i];
      end
      always_comb begin
         if (!y_cur[VecWidth-1]) begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + step_angle(i);
         end else begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - step_angle(i);
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   assign angle = z_ff[CordicIters];

endmodule
`default_nettype wire

[rtl/ackermann_wheel_angles.sv]
// top level: clamp, rotation cordic, geometry products, two vectoring cordics
// depends on awa_pkg and awa_vec_cordic
`default_nettype none
// Ackermann front-wheel angles. Each req beat carries one signed Q3.13 centre
// steering angle; each rsp beat carries the left and right wheel yaw (Q2.13)
// and a geometry fault flag. The pipeline is fully registered: one beat is
// accepted every cycle unless rsp stalls; a result passes the input stage, 16
// rotation cordic stages, multiply and denominator stages, 16 vectoring cordic
// stages and the output register. When rsp is stalled the whole pipeline holds.
// The user must write registers through the csr port only while idle; the block does not enforce it.
module ackermann_wheel_angles
   import awa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // steer_angle
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // left_wheel_angle, right_wheel_angle, geometry_fault
);

   logic [11:0] wheelbase_ff, track_ff;
   logic [13:0] limit_ff;
   logic [7:0]  dead_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff <= 12'd768;
         track_ff <= 12'd614;
         limit_ff <= 14'd4289;
         dead_ff <= 8'd0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            RegWheelbase: wheelbase_ff <= csr_pwdata[11:0];
            RegTrackWidth: track_ff <= csr_pwdata[11:0];
            RegSteerLimit: limit_ff <= csr_pwdata[13:0];
            default: dead_ff <= csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         RegWheelbase: csr_prdata = {20'd0, wheelbase_ff};
         RegTrackWidth: csr_prdata = {20'd0, track_ff};
         RegSteerLimit: csr_prdata = {18'd0, limit_ff};
         default: csr_prdata = {24'd0, dead_ff};
      endcase
   end

   logic advance;
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // input stage: clamp and dead zone
   logic signed [16:0] lim, d_raw, d_cl;
   logic [16:0]        mag;
   side_type           s0_in;
   always_comb begin
      lim = (limit_ff > 14'(HalfPi)) ? 17'(HalfPi) : {3'd0, limit_ff};
      d_raw = {req_tdata[15], req_tdata};
      if (d_raw > lim) d_cl = lim;
      else if (d_raw < -lim) d_cl = -lim;
      else d_cl = d_raw;
      mag = d_cl[16] ? 17'(-d_cl) : d_cl;
      s0_in.valid = req_tvalid;
      s0_in.zero = (d_cl == 17'sd0) || (mag < {9'd0, dead_ff});
      s0_in.pos = !d_cl[16] && (d_cl != 17'sd0);
      s0_in.fault_left = 1'b0;
      s0_in.fault_right = 1'b0;
   end

   logic signed [RotWidth-1:0] rx_ff [0:CordicIters];
   logic signed [RotWidth-1:0] ry_ff [0:CordicIters];
   logic signed [RotWidth-1:0] rz_ff [0:CordicIters];
   side_type                   rs_ff [0:CordicIters];

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff[0] <= '0;
      end else if (advance) begin
         rs_ff[0] <= s0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rx_ff[0] <= RotWidth'(64'sd1 <<< 30);
         ry_ff[0] <= '0;
         rz_ff[0] <= RotWidth'(d_cl) <<< FShift;
      end
   end

   for (genvar i = 0; i < CordicIters; i++) begin : g_rot
      logic signed [RotWidth-1:0] x_in, y_in, z_in;
      always_comb begin
         if (!rz_ff[i][RotWidth-1]) begin
            x_in = rx_ff[i] - (ry_ff[i] >>> i);
            y_in = ry_ff[i] + (rx_ff[i] >>> i);
            z_in = rz_ff[i] - RotWidth'(step_angle(i));
         end else begin
            x_in = rx_ff[i] + (ry_ff[i] >>> i);
            y_in = ry_ff[i] - (rx_ff[i] >>> i);
            z_in = rz_ff[i] + RotWidth'(step_angle(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rs_ff[i+1] <= '0;
         end else if (advance) begin
            rs_ff[i+1] <= rs_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rx_ff[i+1] <= x_in;
            ry_ff[i+1] <= y_in;
            rz_ff[i+1] <= z_in;
         end
      end
   end

   // multiply stage
   logic signed [MulWidth-1:0] ly_ff, lx_ff, ty_ff;
   side_type                   ms_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff <= '0;
      end else if (advance) begin
         ms_ff <= rs_ff[CordicIters];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ly_ff <= MulWidth'($signed({1'b0, wheelbase_ff}) * ry_ff[CordicIters]);
         lx_ff <= MulWidth'($signed({1'b0, wheelbase_ff}) * rx_ff[CordicIters]);
         ty_ff <= MulWidth'($signed({1'b0, track_ff}) * ry_ff[CordicIters]);
      end
   end

   // denominator stage
   logic signed [VecWidth-1:0] num_in, denl_in, denr_in;
   logic signed [VecWidth-1:0] num_ff, denl_ff, denr_ff;
   side_type                   ds_in, ds_ff;
   always_comb begin
      num_in = VecWidth'(ly_ff) <<< 1;
      denl_in = (VecWidth'(lx_ff) <<< 1) - VecWidth'(ty_ff);
      denr_in = (VecWidth'(lx_ff) <<< 1) + VecWidth'(ty_ff);
      ds_in = ms_ff;
      ds_in.fault_left = denl_in[VecWidth-1] || (denl_in == '0);
      ds_in.fault_right = denr_in[VecWidth-1] || (denr_in == '0);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff <= '0;
      end else if (advance) begin
         ds_ff <= ds_in;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
         denl_ff <= denl_in;
         denr_ff <= denr_in;
      end
   end

   logic signed [ZWidth-1:0] zl, zr;
   awa_vec_cordic u_left (
      .clock(clock), .advance(advance), .den(denl_ff), .num(num_ff), .angle(zl)
   );
   awa_vec_cordic u_right (
      .clock(clock), .advance(advance), .den(denr_ff), .num(num_ff), .angle(zr)
   );

   side_type vs_ff [1:CordicIters];
   for (genvar i = 1; i <= CordicIters; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[i] <= '0;
         end else if (advance) begin
            vs_ff[i] <= (i == 1) ? ds_ff : vs_ff[(i == 1) ? 1 : i-1];
         end
      end
   end

   // output stage: round, clamp, saturate
   logic signed [ZWidth-1:0] al_r, ar_r;
   logic signed [14:0]       al, ar, left_in, right_in, hp_s;
   side_type                 vo;
   always_comb begin
      vo = vs_ff[CordicIters];
      hp_s = vo.pos ? 15'(HalfPi) : 15'(-HalfPi);
      al_r = (zl + ZWidth'(1 <<< (FShift-1))) >>> FShift;
      ar_r = (zr + ZWidth'(1 <<< (FShift-1))) >>> FShift;
      if (al_r > ZWidth'(HalfPi)) al = 15'(HalfPi);
      else if (al_r < -ZWidth'(HalfPi)) al = 15'(-HalfPi);
      else al = al_r[14:0];
      if (ar_r > ZWidth'(HalfPi)) ar = 15'(HalfPi);
      else if (ar_r < -ZWidth'(HalfPi)) ar = 15'(-HalfPi);
      else ar = ar_r[14:0];
      left_in = vo.zero ? 15'sd0 : (vo.fault_left ? hp_s : al);
      right_in = vo.zero ? 15'sd0 : (vo.fault_right ? hp_s : ar);
   end

   logic        out_valid_ff;
   logic [31:0] out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vo.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {1'b0, !vo.zero && (vo.fault_left || vo.fault_right),
                         right_in, left_in};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

endmodule
`default_nettype wire

[sim/tb_ackermann_wheel_angles.sv]
// testbench for ackermann_wheel_angles: directed and random steering angles
// against a fixed-point cordic predictor; needs awa_pkg and the block rtl
`timescale 1ns / 100ps
module tb_ackermann_wheel_angles
   import awa_pkg::*;
();

   typedef struct packed {
      logic fault;
      logic [14:0] right;
      logic [14:0] left;
   } wheel_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // steer_angle
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // left_wheel_angle, right_wheel_angle, geometry_fault

   longint         wb = 768, tw = 614, lim_reg = 4289, dz = 0;
   wheel_beat_type angles_due[$];
   int             errors = 0;
   longint         cycles = 0;
   bit             stall_en = 1'b1;

   localparam longint HalfPiQ30 = 64'sd1686629713;
   localparam longint CycleLimit = 400000;

   ackermann_wheel_angles u_dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic longint fl_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint step_q30(int i);
      longint a[16] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                        262143, 131071, 65535, 32767};
      return a[i];
   endfunction

   function automatic longint half_pi_q13();
      return fl_shr(HalfPiQ30 + (64'sd1 << (FShift - 1)), FShift);
   endfunction

   function automatic longint wheel_yaw(longint num, longint den, bit pos, ref bit fault);
      longint x, y, z, nx, hp, a;
      hp = half_pi_q13();
      if (den <= 0) begin
         fault = 1'b1;
         return pos ? hp : -hp;
      end
      x = den; y = num; z = 0;
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += step_q30(i);
         end else begin
            nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= step_q30(i);
         end
         x = nx;
      end
      a = fl_shr(z + (64'sd1 << (FShift - 1)), FShift);
      if (a > hp) a = hp;
      if (a < -hp) a = -hp;
      return a;
   endfunction

   function automatic wheel_beat_type predict_angles(logic signed [15:0] steer);
      longint d, lim, hp, mag, x, y, z, nx, num, l, r;
      bit fault;
      wheel_beat_type w;
      d = steer; hp = half_pi_q13(); lim = lim_reg; fault = 0; l = 0; r = 0;
      if (lim > hp) lim = hp;
      if (d > lim) d = lim;
      if (d < -lim) d = -lim;
      mag = d < 0 ? -d : d;
      if (d != 0 && mag >= dz) begin
         x = 64'sd1 << 30; y = 0; z = d <<< FShift;
         for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
               nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= step_q30(i);
            end else begin
               nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += step_q30(i);
            end
            x = nx;
         end
         num = 2 * wb * y;
         l = wheel_yaw(num, 2 * wb * x - tw * y, d > 0, fault);
         r = wheel_yaw(num, 2 * wb * x + tw * y, d > 0, fault);
      end
      w.left = l[14:0]; w.right = r[14:0]; w.fault = fault;
      return w;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      wheel_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[30:0];
         if (angles_due.size() == 0) report_mismatch("unexpected beat", got, 0);
         else begin
            want = angles_due.pop_front();
            if (got.left != want.left) report_mismatch("left", got.left, want.left);
            if (got.right != want.right) report_mismatch("right", got.right, want.right);
            if (got.fault != want.fault) report_mismatch("fault", got.fault, want.fault);
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   task automatic send_angle(logic [15:0] steer);
      int gap;
      gap = stall_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= steer;
      do @(posedge clock); while (!req_tready);
      angles_due.push_back(predict_angles(steer));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, longint value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value[31:0];
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         RegWheelbase: wb = value;
         RegTrackWidth: tw = value;
         RegSteerLimit: lim_reg = value;
         default: dz = value;
      endcase
   endtask

   task automatic set_geometry(longint l, longint t, longint lim, longint d);
      drain_results();
      write_reg(RegWheelbase, l);
      write_reg(RegTrackWidth, t);
      write_reg(RegSteerLimit, lim);
      write_reg(RegDeadZone, d);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic test_directed_extremes();
      logic [15:0] v[] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'd4289,
                           -16'sd4289, 16'd5000, -16'sd5000, 16'd12868, -16'sd12868,
                           16'd100, -16'sd100, 16'haaaa, 16'h5555};
      foreach (v[i]) send_angle(v[i]);
      set_geometry(768, 614, 16383, 0);
      foreach (v[i]) send_angle(v[i]);
   endtask

   task automatic test_dead_zone();
      set_geometry(768, 614, 4289, 255);
      for (int k = 250; k < 260; k++) begin
         send_angle(k[15:0]);
         send_angle(-k[15:0]);
      end
   endtask

   task automatic test_geometry_fault();
      set_geometry(1, 4095, 12867, 0);
      send_angle(16'd12000); send_angle(-16'sd12000); send_angle(16'd10);
      set_geometry(4095, 0, 12867, 0);
      send_angle(16'd12867); send_angle(-16'sd12867);
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 6; ph++) begin
         set_geometry(longint'($urandom_range(1, 4095)), longint'($urandom_range(0, 4095)),
                      longint'($urandom_range(0, 12867)), longint'($urandom_range(0, 255)));
         for (int n = 0; n < 250; n++)
            send_angle($urandom_range(0, 3) == 0 ? 16'($urandom())
                                                 : 16'($urandom_range(0, 16000) - 8000));
         if (ph == 2) drain_results();
      end
   endtask

   task automatic test_full_rate();
      set_geometry(768, 614, 4289, 0);
      stall_en = 1'b0;
      for (int n = 0; n < 250; n++) send_angle(16'($urandom()));
      stall_en = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_dead_zone();
      test_geometry_fault();
      test_random_settings();
      test_full_rate();
      drain_results();
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

[ackermann_wheel_angles.f]
rtl/awa_pkg.sv
rtl/awa_vec_cordic.sv
rtl/ackermann_wheel_angles.sv
sim/tb_ackermann_wheel_angles.sv
